/* hdl/bdi_pkg.sv */
// Package for the block distribution index unit: status codes, register indexes,
// widths and the clamp functions used by the top level; the radix divider shares the widths.
// No dependencies.
`default_nettype none
package bdi_pkg;

	localparam int MAX_AXES = 3;
	localparam int MAX_BLOCKS_PER_AXIS = 1024;
	localparam int QUO_W = 31;   // quotient bits of every divider
	localparam int REM_W = 10;   // remainder bits of a radix divider

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RANK = 2'd1;
	localparam logic [1:0] STAT_OFFSET = 2'd2;

	localparam logic [2:0] REG_DIMENSIONS = 3'd0;
	localparam logic [2:0] REG_BLOCKS_X = 3'd1;
	localparam logic [2:0] REG_BLOCKS_Y = 3'd2;
	localparam logic [2:0] REG_BLOCKS_Z = 3'd3;
	localparam logic [2:0] REG_FIRST_RANK = 3'd4;
	localparam logic [2:0] REG_RANK_COUNT = 3'd5;

	// sideband carried alongside the radix dividers
	typedef struct packed {
		logic [30:0] share;
		logic [1:0]  status;
		logic [1:0]  axes;
		logic [10:0] ry;
		logic [10:0] rz;
		logic [9:0]  idx_x;
		logic [9:0]  idx_y;
	} bdi_side_t;

	function automatic logic [10:0] axis_clamp(input logic [10:0] v);
		logic [10:0] r;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > 11'(MAX_BLOCKS_PER_AXIS)) begin
			r = 11'(MAX_BLOCKS_PER_AXIS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [1:0] axes_clamp(input logic [1:0] v);
		logic [1:0] r;
		if (v == 2'd0) begin
			r = 2'd1;
		end else if (v > 2'(MAX_AXES)) begin
			r = 2'(MAX_AXES);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/block_distribution_index_unit.sv */
// Block distribution index unit: share of an evenly split block grid per rank and
// the per-axis indices of a block in that share. Depends on bdi_pkg, bdi_radix_div.
`default_nettype none
// Channel   Dir   Handshake                    Payload
// s_*       in    s_tvalid / s_tready          tdata: rank, offset
// m_*       out   m_tvalid / m_tready          tdata: share_count, index x/y/z; tuser: status
// APB       in    psel, penable, pwrite, pready  six 32-bit registers at 4*index
//
// One transfer accepted per cycle while the output is not stalled on m_tready.
// The pipeline holds the rank divider (31 stages, one quotient bit each) and the
// three radix dividers (31 stages each) behind four set-up stages and one adder stage.
// Reset clears valid bits and loads the register reset values; payload is not reset.
// A stall on m_tready freezes the whole pipeline and drops s_tready in the same cycle.
module block_distribution_index_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// rank [15:0], offset [45:16], zero [47:46]
	input  wire logic [47:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// share_count [30:0], index_x [40:31], index_y [50:41], index_z [60:51], zero [63:61]
	output logic [63:0]      m_tdata,
	// status [1:0]
	output logic [1:0]       m_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ---- configuration registers ----
	logic [1:0]  dimensions_q;
	logic [10:0] blocks_x_q, blocks_y_q, blocks_z_q;
	logic [15:0] first_rank_q;
	logic [16:0] rank_count_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q <= 2'd1;
			blocks_x_q <= 11'd1;
			blocks_y_q <= 11'd1;
			blocks_z_q <= 11'd1;
			first_rank_q <= 16'd0;
			rank_count_q <= 17'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				bdi_pkg::REG_DIMENSIONS: dimensions_q <= pwdata[1:0];
				bdi_pkg::REG_BLOCKS_X:   blocks_x_q <= pwdata[10:0];
				bdi_pkg::REG_BLOCKS_Y:   blocks_y_q <= pwdata[10:0];
				bdi_pkg::REG_BLOCKS_Z:   blocks_z_q <= pwdata[10:0];
				bdi_pkg::REG_FIRST_RANK: first_rank_q <= pwdata[15:0];
				bdi_pkg::REG_RANK_COUNT: rank_count_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bdi_pkg::REG_DIMENSIONS: prdata = {30'd0, dimensions_q};
			bdi_pkg::REG_BLOCKS_X:   prdata = {21'd0, blocks_x_q};
			bdi_pkg::REG_BLOCKS_Y:   prdata = {21'd0, blocks_y_q};
			bdi_pkg::REG_BLOCKS_Z:   prdata = {21'd0, blocks_z_q};
			bdi_pkg::REG_FIRST_RANK: prdata = {16'd0, first_rank_q};
			bdi_pkg::REG_RANK_COUNT: prdata = {15'd0, rank_count_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// whole pipeline moves together; the last radix stage is the output register
	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---- stage 1: local rank, range check, clamps, x*y ----
	logic        in_rank_lo;
	logic [15:0] in_rank;
	logic [29:0] in_offset;
	logic [16:0] r_diff;
	logic [16:0] cnt_c;
	logic [1:0]  axes_c;
	logic [10:0] rx_c, ry_c, rz_c;

	assign in_rank = s_tdata[15:0];
	assign in_offset = s_tdata[45:16];
	assign r_diff = {1'b0, in_rank} - {1'b0, first_rank_q};
	assign in_rank_lo = in_rank < first_rank_q;
	assign cnt_c = (rank_count_q == 17'd0) ? 17'd1 : rank_count_q;
	assign axes_c = bdi_pkg::axes_clamp(dimensions_q);
	assign rx_c = bdi_pkg::axis_clamp(blocks_x_q);
	assign ry_c = bdi_pkg::axis_clamp(blocks_y_q);
	assign rz_c = bdi_pkg::axis_clamp(blocks_z_q);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [15:0] r_s1, r_s2;
	logic [29:0] off_s1, off_s2, off_s3, off_s4;
	logic        out_s1, out_s2, out_s3, out_s4;
	logic [1:0]  axes_s1, axes_s2, axes_s3, axes_s4;
	logic [10:0] rx_s1, rx_s2, rx_s3, rx_s4;
	logic [10:0] ry_s1, ry_s2, ry_s3, ry_s4;
	logic [10:0] rz_s1, rz_s2, rz_s3, rz_s4;
	logic [16:0] cnt_s1, cnt_s2, cnt_s3, cnt_s4;
	logic [20:0] rxy_s1;
	logic [30:0] tot_s2, tot_s3, tot_s4;
	logic [46:0] rt_s3, rt_s4, rtl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			r_s1 <= r_diff[15:0];
			off_s1 <= in_offset;
			out_s1 <= in_rank_lo || (r_diff >= cnt_c);
			axes_s1 <= axes_c;
			rx_s1 <= rx_c;
			ry_s1 <= ry_c;
			rz_s1 <= rz_c;
			cnt_s1 <= cnt_c;
			rxy_s1 <= (axes_c == 2'd1) ? {10'd0, rx_c} : 21'(rx_c * ry_c);
			// stage 2: total block count
			r_s2 <= r_s1;
			off_s2 <= off_s1;
			out_s2 <= out_s1;
			axes_s2 <= axes_s1;
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			rz_s2 <= rz_s1;
			cnt_s2 <= cnt_s1;
			tot_s2 <= (axes_s1 == 2'd3) ? 31'(rxy_s1 * rz_s1) : {10'd0, rxy_s1};
			// stage 3: r*T
			off_s3 <= off_s2;
			out_s3 <= out_s2;
			axes_s3 <= axes_s2;
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			rz_s3 <= rz_s2;
			cnt_s3 <= cnt_s2;
			tot_s3 <= tot_s2;
			rt_s3 <= 47'(r_s2 * tot_s2);
			// stage 4: (r+1)*T
			off_s4 <= off_s3;
			out_s4 <= out_s3;
			axes_s4 <= axes_s3;
			rx_s4 <= rx_s3;
			ry_s4 <= ry_s3;
			rz_s4 <= rz_s3;
			cnt_s4 <= cnt_s3;
			tot_s4 <= tot_s3;
			rt_s4 <= rt_s3;
			rtl_s4 <= rt_s3 + {16'd0, tot_s3};
		end
	end

	// ---- rank divider: first and last block of the share, two lanes ----
	// Both quotients stay below 2^31, so the top 16 dividend bits seed the remainder.
	typedef struct packed {
		logic [29:0] offset;
		logic [30:0] total;
		logic        outside;
		logic [1:0]  axes;
		logic [10:0] rx;
		logic [10:0] ry;
		logic [10:0] rz;
		logic [16:0] count;
	} rk_side_t;

	logic        dv_v_s5    [0:bdi_pkg::QUO_W];
	rk_side_t    dv_sd_s5   [0:bdi_pkg::QUO_W];
	logic [16:0] dv_remf_s5 [0:bdi_pkg::QUO_W];
	logic [16:0] dv_reml_s5 [0:bdi_pkg::QUO_W];
	logic [30:0] dv_numf_s5 [0:bdi_pkg::QUO_W];
	logic [30:0] dv_numl_s5 [0:bdi_pkg::QUO_W];
	logic [30:0] dv_quof_s5 [0:bdi_pkg::QUO_W];
	logic [30:0] dv_quol_s5 [0:bdi_pkg::QUO_W];

	assign dv_v_s5[0] = v_s4;
	assign dv_sd_s5[0] = '{offset: off_s4, total: tot_s4, outside: out_s4, axes: axes_s4,
		rx: rx_s4, ry: ry_s4, rz: rz_s4, count: cnt_s4};
	assign dv_remf_s5[0] = {1'b0, rt_s4[46:31]};
	assign dv_reml_s5[0] = {1'b0, rtl_s4[46:31]};
	assign dv_numf_s5[0] = rt_s4[30:0];
	assign dv_numl_s5[0] = rtl_s4[30:0];
	assign dv_quof_s5[0] = '0;
	assign dv_quol_s5[0] = '0;

	for (genvar k = 1; k <= bdi_pkg::QUO_W; k++) begin : g_rank_div
		logic        v_q;
		rk_side_t    sd_q;
		logic [16:0] remf_q, reml_q;
		logic [30:0] numf_q, numl_q, quof_q, quol_q;
		logic [17:0] tf, tl, den;
		logic        gf, gl;

		assign den = {1'b0, dv_sd_s5[k-1].count};
		assign tf = {dv_remf_s5[k-1], dv_numf_s5[k-1][30]};
		assign tl = {dv_reml_s5[k-1], dv_numl_s5[k-1][30]};
		assign gf = tf >= den;
		assign gl = tl >= den;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (adv) begin
				v_q <= dv_v_s5[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_q <= dv_sd_s5[k-1];
				remf_q <= gf ? 17'(tf - den) : tf[16:0];
				reml_q <= gl ? 17'(tl - den) : tl[16:0];
				numf_q <= {dv_numf_s5[k-1][29:0], 1'b0};
				numl_q <= {dv_numl_s5[k-1][29:0], 1'b0};
				quof_q <= {dv_quof_s5[k-1][29:0], gf};
				quol_q <= {dv_quol_s5[k-1][29:0], gl};
			end
		end

		assign dv_v_s5[k] = v_q;
		assign dv_sd_s5[k] = sd_q;
		assign dv_remf_s5[k] = remf_q;
		assign dv_reml_s5[k] = reml_q;
		assign dv_numf_s5[k] = numf_q;
		assign dv_numl_s5[k] = numl_q;
		assign dv_quof_s5[k] = quof_q;
		assign dv_quol_s5[k] = quol_q;
	end

	// ---- stage 6: share, status, global block number ----
	rk_side_t           rk_end;
	logic [30:0]        first_c, last_c;
	logic               v_s6;
	bdi_pkg::bdi_side_t sd_s6;
	logic [30:0]        q_s6;
	logic [10:0]        rx_s6;
	logic [1:0]         stat_c;

	assign rk_end = dv_sd_s5[bdi_pkg::QUO_W];
	assign first_c = dv_quof_s5[bdi_pkg::QUO_W];
	assign last_c = dv_quol_s5[bdi_pkg::QUO_W];

	always_comb begin
		priority if (rk_end.outside) begin
			stat_c = bdi_pkg::STAT_RANK;
		end else if ({1'b0, rk_end.offset} >= rk_end.total) begin
			stat_c = bdi_pkg::STAT_OFFSET;
		end else begin
			stat_c = bdi_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dv_v_s5[bdi_pkg::QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6.share <= rk_end.outside ? 31'd0 : 31'(last_c - first_c);
			sd_s6.status <= stat_c;
			sd_s6.axes <= rk_end.axes;
			sd_s6.ry <= rk_end.ry;
			sd_s6.rz <= rk_end.rz;
			sd_s6.idx_x <= '0;
			sd_s6.idx_y <= '0;
			// below 2T when the offset is in range; wraps on the last axis in use
			q_s6 <= 31'(first_c + {1'b0, rk_end.offset});
			rx_s6 <= rk_end.rx;
		end
	end

	// ---- mixed-radix split, first axis fastest ----
	logic               vx, vy, vz;
	bdi_pkg::bdi_side_t sx, sy, sz, sx_n, sy_n;
	logic [30:0]        qx, qy, qz;
	logic [9:0]         rmx, rmy, rmz;

	bdi_radix_div u_div_x (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v_s6), .in_side(sd_s6), .in_num(q_s6), .in_den(rx_s6),
		.out_valid(vx), .out_side(sx), .out_quo(qx), .out_rem(rmx)
	);

	always_comb begin
		sx_n = sx;
		sx_n.idx_x = rmx;
	end

	bdi_radix_div u_div_y (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(vx), .in_side(sx_n), .in_num(qx), .in_den(sx.ry),
		.out_valid(vy), .out_side(sy), .out_quo(qy), .out_rem(rmy)
	);

	always_comb begin
		sy_n = sy;
		sy_n.idx_y = rmy;
	end

	bdi_radix_div u_div_z (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(vy), .in_side(sy_n), .in_num(qy), .in_den(sy.rz),
		.out_valid(vz), .out_side(sz), .out_quo(qz), .out_rem(rmz)
	);

	// ---- output: indices of unused axes and error cases read 0 ----
	logic       ok;
	logic [9:0] ox, oy, oz;

	assign ok = sz.status == bdi_pkg::STAT_OK;
	assign ox = ok ? sz.idx_x : 10'd0;
	assign oy = (ok && sz.axes >= 2'd2) ? sz.idx_y : 10'd0;
	assign oz = (ok && sz.axes == 2'd3 && qz[0] == qz[0]) ? rmz : 10'd0;

	assign m_tvalid = vz;
	assign m_tdata = {3'd0, oz, oy, ox, sz.share};
	assign m_tuser = sz.status;

	// ---- assertions ----
	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bdi_pkg::STAT_RANK |-> m_tdata == 64'd0)
		else $error("rank outside range gave non-zero fields");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != bdi_pkg::STAT_OK |-> m_tdata[60:31] == 30'd0)
		else $error("error status with non-zero indices");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && !$past(s_tready))
		else $error("stalled result changed or input taken during stall");

endmodule
`default_nettype wire

/* hdl/bdi_radix_div.sv */
// Pipelined restoring divider, 31-bit dividend by 11-bit radix, one quotient bit a stage.
// Carries a bdi_pkg::bdi_side_t alongside. Depends on bdi_pkg.
`default_nettype none
module bdi_radix_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire bdi_pkg::bdi_side_t  in_side,
	input  wire logic [30:0]         in_num,
	input  wire logic [10:0]         in_den,
	output logic                     out_valid,
	output bdi_pkg::bdi_side_t       out_side,
	output logic [30:0]              out_quo,
	output logic [9:0]               out_rem
);

	logic               v_s   [0:bdi_pkg::QUO_W];
	bdi_pkg::bdi_side_t sd_s  [0:bdi_pkg::QUO_W];
	logic [30:0]        num_s [0:bdi_pkg::QUO_W];
	logic [30:0]        quo_s [0:bdi_pkg::QUO_W];
	logic [9:0]         rem_s [0:bdi_pkg::QUO_W];
	logic [10:0]        den_s [0:bdi_pkg::QUO_W];

	assign v_s[0] = in_valid;
	assign sd_s[0] = in_side;
	assign num_s[0] = in_num;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;

	for (genvar k = 1; k <= bdi_pkg::QUO_W; k++) begin : g_stage
		logic               v_q;
		bdi_pkg::bdi_side_t sd_q;
		logic [30:0]        num_q;
		logic [30:0]        quo_q;
		logic [9:0]         rem_q;
		logic [10:0]        den_q;
		logic [10:0]        trial;
		logic               ge;

		assign trial = {rem_s[k-1], num_s[k-1][30]};
		assign ge = trial >= den_s[k-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (adv) begin
				v_q <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_q <= sd_s[k-1];
				den_q <= den_s[k-1];
				num_q <= {num_s[k-1][29:0], 1'b0};
				quo_q <= {quo_s[k-1][29:0], ge};
				rem_q <= ge ? 10'(trial - den_s[k-1]) : trial[9:0];
			end
		end

		assign v_s[k] = v_q;
		assign sd_s[k] = sd_q;
		assign num_s[k] = num_q;
		assign quo_s[k] = quo_q;
		assign rem_s[k] = rem_q;
		assign den_s[k] = den_q;
	end

	assign out_valid = v_s[bdi_pkg::QUO_W];
	assign out_side = sd_s[bdi_pkg::QUO_W];
	assign out_quo = quo_s[bdi_pkg::QUO_W];
	assign out_rem = rem_s[bdi_pkg::QUO_W];

endmodule
`default_nettype wire

/* sim/block_distribution_index_unit_check.sv */
// Checker for the block distribution index unit: watches the query and result
// channels and the APB writes, predicts each result and compares. Depends on bdi_pkg.
module block_distribution_index_unit_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [47:0] s_tdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending,
	output int               results_seen
);

	typedef struct packed {
		logic [30:0] share;
		logic [9:0]  ix;
		logic [9:0]  iy;
		logic [9:0]  iz;
		logic [1:0]  status;
	} placement_t;

	logic [1:0]  dims_r;
	logic [10:0] bx_r, by_r, bz_r;
	logic [15:0] first_r;
	logic [16:0] count_r;
	placement_t  placements_due[$];

	function automatic logic [63:0] clamp_axis(input logic [10:0] v);
		if (v == 0) return 1;
		if (v > bdi_pkg::MAX_BLOCKS_PER_AXIS) return bdi_pkg::MAX_BLOCKS_PER_AXIS;
		return v;
	endfunction

	function automatic placement_t place_block(input logic [15:0] rank,
			input logic [29:0] offset);
		placement_t  p;
		logic [63:0] radix [3];
		logic [63:0] idx [3];
		logic [63:0] total, n, r, first_blk, q;
		int          axes;
		p = '0;
		axes = (dims_r == 0) ? 1 : int'(dims_r);
		radix[0] = clamp_axis(bx_r);
		radix[1] = clamp_axis(by_r);
		radix[2] = clamp_axis(bz_r);
		idx[0] = 0; idx[1] = 0; idx[2] = 0;
		total = 1;
		for (int i = 0; i < axes; i++) total = total * radix[i];
		n = (count_r == 0) ? 1 : 64'(count_r);
		if (rank < first_r || 64'(rank - first_r) >= n) begin
			p.status = bdi_pkg::STAT_RANK;
		end else begin
			r = 64'(rank - first_r);
			first_blk = (r * total) / n;
			p.share = 31'((((r + 1) * total) / n) - first_blk);
			if (64'(offset) >= total) begin
				p.status = bdi_pkg::STAT_OFFSET;
			end else begin
				p.status = bdi_pkg::STAT_OK;
				q = first_blk + 64'(offset);
				for (int i = 0; i < axes; i++) begin
					idx[i] = q % radix[i];
					q = q / radix[i];
				end
			end
		end
		p.ix = idx[0][9:0];
		p.iy = idx[1][9:0];
		p.iz = idx[2][9:0];
		return p;
	endfunction

	assign pending = placements_due.size();

	always @(posedge clk or negedge arst_n) begin
		placement_t exp_p, got;
		if (!arst_n) begin
			dims_r <= 2'd1; bx_r <= 11'd1; by_r <= 11'd1; bz_r <= 11'd1;
			first_r <= '0; count_r <= 17'd1;
			errors <= 0;
			results_seen <= 0;
			placements_due.delete();
		end else begin
			// registers update after this edge; a query in the same edge sees old ones
			if (s_tvalid && s_tready)
				placements_due.push_back(place_block(s_tdata[15:0], s_tdata[45:16]));
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					bdi_pkg::REG_DIMENSIONS: dims_r <= pwdata[1:0];
					bdi_pkg::REG_BLOCKS_X: bx_r <= pwdata[10:0];
					bdi_pkg::REG_BLOCKS_Y: by_r <= pwdata[10:0];
					bdi_pkg::REG_BLOCKS_Z: bz_r <= pwdata[10:0];
					bdi_pkg::REG_FIRST_RANK: first_r <= pwdata[15:0];
					bdi_pkg::REG_RANK_COUNT: count_r <= pwdata[16:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got = {m_tdata[30:0], m_tdata[40:31], m_tdata[50:41], m_tdata[60:51],
					m_tuser};
				if (placements_due.size() == 0) begin
					if (errors < 10) $display("unexpected result %h", got);
					errors <= errors + 1;
				end else begin
					exp_p = placements_due.pop_front();
					if (exp_p !== got || m_tdata[63:61] !== 3'b000) begin
						if (errors < 10) begin
							$display("mismatch: exp share %0d idx %0d/%0d/%0d st %0d,",
								exp_p.share, exp_p.ix, exp_p.iy, exp_p.iz, exp_p.status);
							$display("          got share %0d idx %0d/%0d/%0d st %0d",
								got.share, got.ix, got.iy, got.iz, got.status);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

/* sim/block_distribution_index_unit_test.sv */
// Testbench top for the block distribution index unit: clock, reset, APB set-up,
// query stimulus and verdict. Depends on bdi_pkg and the checker module.
module block_distribution_index_unit_test;

	localparam int LATENCY = 130;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [47:0] s_tdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, results_seen;
	int queries_sent;
	bit hold_off = 1'b0;   // long receiver hold-off, driven by the stimulus process
	bit offering = 1'b0;   // sender is presenting a query

	// current grid, kept here to aim ranks and offsets at interesting values
	int unsigned cur_first, cur_count, cur_total;

	always #4 clk = ~clk;

	block_distribution_index_unit u_top (.*);

	block_distribution_index_unit_check u_check (.*);

	// receiver: own stall pattern, mostly ready, with busy spells and quiet runs
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				if (hold_off) m_tready <= 1'b0;
				else case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// load a full grid setting and remember its effective shape
	task automatic set_grid(input logic [1:0] d, input logic [10:0] x, input logic [10:0] y,
			input logic [10:0] z, input logic [15:0] f, input logic [16:0] n);
		int unsigned ax;
		int unsigned t;
		reg_write(bdi_pkg::REG_DIMENSIONS, 32'(d));
		reg_write(bdi_pkg::REG_BLOCKS_X, 32'(x));
		reg_write(bdi_pkg::REG_BLOCKS_Y, 32'(y));
		reg_write(bdi_pkg::REG_BLOCKS_Z, 32'(z));
		reg_write(bdi_pkg::REG_FIRST_RANK, 32'(f));
		reg_write(bdi_pkg::REG_RANK_COUNT, 32'(n));
		ax = (d == 0) ? 1 : d;
		t = (x == 0) ? 1 : (x > 1024 ? 1024 : x);
		if (ax > 1) t = t * ((y == 0) ? 1 : (y > 1024 ? 1024 : y));
		if (ax > 2) t = t * ((z == 0) ? 1 : (z > 1024 ? 1024 : z));
		cur_first = f;
		cur_count = (n == 0) ? 1 : n;
		cur_total = t;
	endtask

	// one query: held until the transfer goes through
	task automatic send_query(input logic [15:0] rank, input logic [29:0] offset);
		@(posedge clk);
		s_tdata <= {2'b00, offset, rank};
		s_tvalid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		queries_sent++;
		// lower valid only if no back-to-back query follows; caller decides gaps
	endtask

	task automatic pause_query;
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		pause_query();
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// back-to-back sender without the extra edge of send_query
	task automatic stream_query(input logic [15:0] rank, input logic [29:0] offset);
		s_tdata <= {2'b00, offset, rank};
		s_tvalid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		queries_sent++;
	endtask

	function automatic logic [15:0] pick_rank;
		int unsigned r;
		case ($urandom_range(0, 9))
			0: r = $urandom_range(0, 65535);
			1: r = cur_first + cur_count - 1;
			2: r = cur_first;
			3: r = (cur_first > 0) ? cur_first - 1 : cur_first + cur_count;
			default: r = cur_first + $urandom_range(0, cur_count - 1);
		endcase
		return r[15:0];
	endfunction

	function automatic logic [29:0] pick_offset;
		case ($urandom_range(0, 9))
			0: return 30'($urandom());
			1: return 30'(cur_total - 1);
			2: return 30'(cur_total);
			3: return 30'h3FFFFFFF;
			default: return 30'($urandom_range(0, cur_total - 1));
		endcase
	endfunction

	// random burst phase on the present grid
	task automatic random_phase(input int n);
		int k;
		k = 0;
		while (k < n) begin
			repeat ($urandom_range(1, 24)) begin
				if (k < n) begin
					stream_query(pick_rank(), pick_offset());
					k++;
				end
			end
			if ($urandom_range(0, 2) != 0) begin
				pause_query();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		pause_query();
	endtask

	initial begin
		queries_sent = 0;
		cur_first = 0; cur_count = 1; cur_total = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset registers: one block, one rank
		stream_query(16'd0, 30'd0);
		stream_query(16'd1, 30'd0);
		stream_query(16'd0, 30'd1);
		drain();

		// zero dimensions and zero axes read as one; rank count zero reads as one
		set_grid(2'd0, 11'd0, 11'd0, 11'd0, 16'd0, 17'd0);
		stream_query(16'd0, 30'd0);
		stream_query(16'hFFFF, 30'd0);
		drain();

		// oversized axes clamp; full three-axis grid, widest rank range
		set_grid(2'd3, 11'h7FF, 11'd1024, 11'd1500, 16'd0, 17'h10000);
		stream_query(16'd0, 30'd0);
		stream_query(16'hFFFF, 30'h3FFFFFFF);
		stream_query(16'hFFFF, 30'd1073741823);
		stream_query(16'd32768, 30'd5);
		stream_query(16'hFFFF, 30'h2AAAAAAA);
		drain();

		// offsets past the share wrap; last rank, rank below range, above range
		set_grid(2'd2, 11'd7, 11'd5, 11'd3, 16'd100, 17'd4);
		stream_query(16'd100, 30'd30);
		stream_query(16'd103, 30'd34);
		stream_query(16'd103, 30'd35);
		stream_query(16'd99, 30'd0);
		stream_query(16'd104, 30'd0);
		stream_query(16'hFFFF, 30'h15555555);
		drain();

		// first rank at top of range, more ranks than blocks
		set_grid(2'd1, 11'd3, 11'd9, 11'd9, 16'hFFFF, 17'h1FFFF);
		stream_query(16'hFFFF, 30'd2);
		stream_query(16'hFFFE, 30'd0);
		drain();

		// random phases across several grids, extremes among them
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_grid(2'd3, 11'd1024, 11'd1024, 11'd1024, 16'd0, 17'd65536);
				1: set_grid(2'd1, 11'd1, 11'd1, 11'd1, 16'd65535, 17'd1);
				default: set_grid(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
					11'($urandom_range(0, 40)), 11'($urandom_range(0, 1100)),
					16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
			endcase
			if (ph == 4) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
					random_phase(300);
				join
			end else begin
				random_phase(120);
			end
			drain();
		end

		$display("summary: %0d queries, %0d results checked over directed and random grids",
			queries_sent, results_seen);
		$display("  reset values, clamped axes, wrap past share, out-of-range ranks/offsets");
		if (errors == 0 && pending == 0) begin
			$display("block_distribution_index_unit_test: done, clean");
		end else begin
			$display("block_distribution_index_unit_test: done, errors");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("block_distribution_index_unit_test: done, errors");
		$finish;
	end

endmodule
